@@ rtl/mep_pkg.sv @@
`default_nettype none

package mep_pkg;

   localparam int COORD_W    = 12;
   localparam int COLOR_W    = 32;
   localparam int COUNT_W    = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RAMP_LEN   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_X_START    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_START    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 3'd4;

   localparam logic signed [31:0] X_START_RESET = -32'sd536870912;
   localparam logic signed [31:0] Y_START_RESET = 32'sd268435456;
   localparam logic [30:0]        X_STEP_RESET  = 31'd503316;
   localparam logic [30:0]        Y_STEP_RESET  = 31'd596523;
   localparam logic [COUNT_W-1:0] LIMIT_RESET   = 10'd100;

   localparam logic [COLOR_W-1:0] RAMP [RAMP_LEN] = '{
      32'h1010FFFF, 32'h1710F3FF, 32'h1E10E8FF, 32'h2611DCFF,
      32'h2D11D1FF, 32'h3512C5FF, 32'h3C12BAFF, 32'h4313AEFF,
      32'h4B13A3FF, 32'h521497FF, 32'h5A148CFF, 32'h611480FF,
      32'h681575FF, 32'h701569FF, 32'h77165EFF, 32'h7D1654FF
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MCX,
      ST_MCY,
      ST_CY,
      ST_SQX,
      ST_SQY,
      ST_XY,
      ST_UPD,
      ST_OUT
   } mep_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mep_if.sv @@
`default_nettype none

interface mep_req_if;
   logic                        valid;
   logic                        ready;
   logic [mep_pkg::COORD_W-1:0] column;
   logic [mep_pkg::COORD_W-1:0] row;

   modport source (output valid, output column, output row, input ready);
   modport sink   (input valid, input column, input row, output ready);
endinterface

interface mep_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mep_pkg::COLOR_W-1:0] color;
   logic [mep_pkg::COUNT_W-1:0] iteration_count;

   modport source (output valid, output color, output iteration_count, input ready);
   modport sink   (input valid, input color, input iteration_count, output ready);
endinterface

`default_nettype wire

@@ rtl/mandelbrot_escape_pixel_unit.sv @@
// channel | dir | transfer when       | payload
// req     | in  | valid && ready      | column[11:0], row[11:0]
// rsp     | out | valid && ready      | color[31:0], iteration_count[9:0]
// csr     | in  | csr_we              | csr_index[2:0], csr_wdata[31:0]
//
// A pixel is computed iteratively:
// each iteration runs three products and one update through the single
// registered 32x32 multiplier. One pixel at a time; req_ready is high only in idle.
// A finished result waits in the rsp register; the next pixel may start meanwhile.
// Reset is synchronous and restores the register defaults.
`default_nettype none

module mandelbrot_escape_pixel_unit #(
   parameter int PALETTE_ENTRIES = 16,
   parameter int FRACTION_BITS   = 28
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   mep_req_if.sink                           req_chan,
   mep_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_we,
   input  wire logic [mep_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mep_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mep_pkg::*;

   localparam int PAL_W = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam bit ESC_ON = (2 * FRACTION_BITS + 2) <= 63;
   localparam logic [63:0] ESC_LIMIT = ESC_ON ? (64'd4 << (2 * FRACTION_BITS)) : 64'd0;

   logic signed [31:0]  x_start_ff, y_start_ff;
   logic [30:0]         x_step_ff, y_step_ff;
   logic [COUNT_W-1:0]  limit_ff;

   mep_state_type       state_ff, state_in;

   logic [COORD_W-1:0]  col_ff, row_ff;
   logic signed [31:0]  cx_ff, cy_ff, vx_ff, vy_ff;
   logic signed [63:0]  acc_ff, diff_ff;
   logic                esc_ff;
   logic [COUNT_W-1:0]  iter_ff;
   logic [PAL_W-1:0]    pal_ff;

   logic                rsp_valid_ff;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic [COUNT_W-1:0]  count_ff;

   logic signed [31:0]  mul_a, mul_b;
   logic signed [63:0]  prod_ff;
   logic [63:0]         mag_sum;
   logic                done;
   logic                out_free;
   logic [8:0]          pal_wide;

   mep_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod_ff)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff <= X_START_RESET;
         y_start_ff <= Y_START_RESET;
         x_step_ff  <= X_STEP_RESET;
         y_step_ff  <= Y_STEP_RESET;
         limit_ff   <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_X_START:    x_start_ff <= signed'(csr_wdata);
            CSR_Y_START:    y_start_ff <= signed'(csr_wdata);
            CSR_X_STEP:     x_step_ff  <= csr_wdata[30:0];
            CSR_Y_STEP:     y_step_ff  <= csr_wdata[30:0];
            CSR_ITER_LIMIT: limit_ff   <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign mag_sum  = unsigned'(acc_ff) + unsigned'(prod_ff);
   assign done     = (iter_ff >= limit_ff) || esc_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pal_wide = 9'(pal_ff);

   always_comb begin
      if (iter_ff != '0 && iter_ff < limit_ff) begin
         color_in = RAMP[pal_wide[3:0]];
      end else if (esc_ff) begin
         color_in = RAMP[0];
      end else begin
         color_in = '0;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_a    = vx_ff;
      mul_b    = vx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_MCX;
         end
         ST_MCX: begin
            mul_a    = signed'(32'(col_ff));
            mul_b    = signed'({1'b0, x_step_ff});
            state_in = ST_MCY;
         end
         ST_MCY: begin
            mul_a    = signed'(32'(row_ff));
            mul_b    = signed'({1'b0, y_step_ff});
            state_in = ST_CY;
         end
         ST_CY:  state_in = ST_SQX;
         ST_SQX: state_in = ST_SQY;
         ST_SQY: begin
            mul_a    = vy_ff;
            mul_b    = vy_ff;
            state_in = ST_XY;
         end
         ST_XY: begin
            mul_a    = vx_ff;
            mul_b    = vy_ff;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            state_in = done ? ST_OUT : ST_SQX;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            col_ff <= req_chan.column;
            row_ff <= req_chan.row;
         end
         ST_MCY: begin
            cx_ff <= sat32(64'(x_start_ff) + prod_ff);
            vx_ff <= sat32(64'(x_start_ff) + prod_ff);
         end
         ST_CY: begin
            cy_ff   <= sat32(64'(y_start_ff) - prod_ff);
            vy_ff   <= sat32(64'(y_start_ff) - prod_ff);
            iter_ff <= '0;
            pal_ff  <= '0;
         end
         ST_SQY: acc_ff <= prod_ff;
         ST_XY: begin
            esc_ff  <= ESC_ON && (mag_sum > ESC_LIMIT);
            diff_ff <= acc_ff - prod_ff;
         end
         ST_UPD: begin
            if (!done) begin
               vx_ff   <= sat32((diff_ff >>> FRACTION_BITS) + 64'(cx_ff));
               vy_ff   <= sat32((prod_ff >>> (FRACTION_BITS - 1)) + 64'(cy_ff));
               iter_ff <= iter_ff + 1'b1;
               pal_ff  <= (pal_ff == PAL_W'(PALETTE_ENTRIES - 1)) ? '0 : pal_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         color_ff <= color_in;
         count_ff <= iter_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.color           = color_ff;
   assign rsp_chan.iteration_count = count_ff;

endmodule

`default_nettype wire

@@ rtl/mep_mul.sv @@
`default_nettype none

module mep_mul (
   input  wire logic               clock,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   output logic signed [63:0]      prod_ff
);

   logic signed [63:0] prod_in;

   assign prod_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

@@ rtl/mep_chk.sv @@
`default_nettype none

module mep_chk (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [mep_pkg::COLOR_W-1:0] rsp_color,
   input wire logic [mep_pkg::COUNT_W-1:0] rsp_count
);
   import mep_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color) && $stable(rsp_count))
      else $error("rsp changed while stalled");

   // one pixel at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a transfer");

   // no iteration means no ramp color other than the first entry
   a_zero_count_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count == '0 |-> rsp_color == RAMP[0] || rsp_color == '0)
      else $error("bad color for zero iterations");

endmodule

bind mandelbrot_escape_pixel_unit mep_chk u_mep_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_color (rsp_chan.color),
   .rsp_count (rsp_chan.iteration_count)
);

`default_nettype wire

@@ tb/mandelbrot_escape_pixel_unit_tb.sv @@
module mandelbrot_escape_pixel_unit_tb;

   localparam int FRAC        = 28;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 1000;
   localparam int TAIL_CYCLES = 60;
   localparam logic [63:0] RADIUS_SQ = 64'd4 << (2 * FRAC);

   localparam logic [31:0] SHADE [16] = '{
      32'h1010FFFF, 32'h1710F3FF, 32'h1E10E8FF, 32'h2611DCFF,
      32'h2D11D1FF, 32'h3512C5FF, 32'h3C12BAFF, 32'h4313AEFF,
      32'h4B13A3FF, 32'h521497FF, 32'h5A148CFF, 32'h611480FF,
      32'h681575FF, 32'h701569FF, 32'h77165EFF, 32'h7D1654FF
   };

   typedef struct packed {
      logic [mep_pkg::COLOR_W-1:0] color;
      logic [mep_pkg::COUNT_W-1:0] count;
   } pixel_shade_type;

   class escape_ledger_type;
      pixel_shade_type    pending[$];
      logic signed [31:0] x_origin;
      logic signed [31:0] y_origin;
      logic [30:0]        x_pitch;
      logic [30:0]        y_pitch;
      logic [9:0]         depth;
      int                 faults;
      int                 checked;
      int                 inside_count;

      function new();
         x_origin     = mep_pkg::X_START_RESET;
         y_origin     = mep_pkg::Y_START_RESET;
         x_pitch      = mep_pkg::X_STEP_RESET;
         y_pitch      = mep_pkg::Y_STEP_RESET;
         depth        = mep_pkg::LIMIT_RESET;
         faults       = 0;
         checked      = 0;
         inside_count = 0;
      endfunction

      function void set_register(input logic [mep_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [31:0] data);
         case (idx)
            mep_pkg::CSR_X_START:    x_origin = data;
            mep_pkg::CSR_Y_START:    y_origin = data;
            mep_pkg::CSR_X_STEP:     x_pitch  = data[30:0];
            mep_pkg::CSR_Y_STEP:     y_pitch  = data[30:0];
            mep_pkg::CSR_ITER_LIMIT: depth    = data[9:0];
            default: ;
         endcase
      endfunction

      function logic signed [31:0] pin32(input longint v);
         if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
         end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
         end
         return v[31:0];
      endfunction

      function bit beyond_radius(input logic signed [31:0] zx, input logic signed [31:0] zy);
         longint      px;
         longint      py;
         logic [63:0] mag;
         px  = longint'(zx) * longint'(zx);
         py  = longint'(zy) * longint'(zy);
         mag = px + py;
         return mag > RADIUS_SQ;
      endfunction

      function pixel_shade_type escape_time(input logic [11:0] col, input logic [11:0] row);
         logic signed [31:0] cx;
         logic signed [31:0] cy;
         logic signed [31:0] zx;
         logic signed [31:0] zy;
         longint             px;
         longint             py;
         longint             cr;
         int                 n;
         pixel_shade_type    r;
         cx = pin32(longint'(x_origin) + longint'(col) * longint'(x_pitch));
         cy = pin32(longint'(y_origin) - longint'(row) * longint'(y_pitch));
         zx = cx;
         zy = cy;
         n  = 0;
         while (n < depth && !beyond_radius(zx, zy)) begin
            px = longint'(zx) * longint'(zx);
            py = longint'(zy) * longint'(zy);
            cr = longint'(zx) * longint'(zy);
            zx = pin32(((px - py) >>> FRAC) + longint'(cx));
            zy = pin32((cr >>> (FRAC - 1)) + longint'(cy));
            n++;
         end
         r.count = 10'(n);
         if (n > 0 && n < depth) begin
            r.color = SHADE[n % 16];
         end else if (beyond_radius(zx, zy)) begin
            r.color = SHADE[0];
         end else begin
            r.color = '0;
         end
         return r;
      endfunction

      function void note_pixel(input logic [11:0] col, input logic [11:0] row);
         pending.push_back(escape_time(col, row));
      endfunction

      function void check_pixel(input logic [31:0] color, input logic [9:0] count);
         pixel_shade_type want;
         if (pending.size() == 0) begin
            $error("result with no pixel waiting: color %h iteration_count %0d", color, count);
            faults++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.color == '0) begin
            inside_count++;
         end
         if (color !== want.color) begin
            $error("color: expected %h, actual %h", want.color, color);
            faults++;
         end
         if (count !== want.count) begin
            $error("iteration_count: expected %0d, actual %0d", want.count, count);
            faults++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_we;
   logic [mep_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [mep_pkg::CSR_DATA_W-1:0]    csr_wdata;
   escape_ledger_type                 ledger;
   bit                                hold_pending = 1'b0;
   int                                quiet_cycles = 0;
   int                                view_count = 0;

   mep_req_if req_chan ();
   mep_rsp_if rsp_chan ();

   mandelbrot_escape_pixel_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 120);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            ledger.check_pixel(rsp_chan.color, rsp_chan.iteration_count);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, ledger.outstanding());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 1)) begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat (idle_gap() + 1) @(posedge clock);
         end
      end
   end

   task automatic send_pixel(input logic [11:0] col, input logic [11:0] row, input int gap);
      req_chan.valid  <= 1'b1;
      req_chan.column <= col;
      req_chan.row    <= row;
      do @(posedge clock); while (!req_chan.ready);
      ledger.note_pixel(col, row);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic scatter_pixels(input int n, input int col_hi, input int row_hi);
      repeat (n) begin
         send_pixel(12'($urandom_range(0, col_hi)), 12'($urandom_range(0, row_hi)),
                    idle_gap());
      end
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      while (ledger.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [mep_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      ledger.set_register(idx, data);
   endtask

   task automatic load_view(input logic [31:0] xs, input logic [31:0] ys,
                            input logic [31:0] xst, input logic [31:0] yst,
                            input logic [31:0] lim);
      drain();
      write_register(mep_pkg::CSR_X_START, xs);
      write_register(mep_pkg::CSR_Y_START, ys);
      write_register(mep_pkg::CSR_X_STEP, xst);
      write_register(mep_pkg::CSR_Y_STEP, yst);
      write_register(mep_pkg::CSR_ITER_LIMIT, lim);
      csr_we <= 1'b0;
      view_count++;
   endtask

   task automatic random_view(input int lim_lo, input int lim_hi);
      logic [31:0] xs;
      logic [31:0] ys;
      xs = -$urandom_range(134217728, 603979776);
      ys = $urandom_range(134217728, 402653184);
      load_view(xs, ys, $urandom_range(13107, 196608), $urandom_range(13107, 196608),
                $urandom_range(lim_lo, lim_hi));
   endtask

   initial begin
      ledger          = new();
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_chan.valid  = 1'b0;
      req_chan.column = '0;
      req_chan.row    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // corners, inside points, slow escapes near the cusp, alternating bits
      send_pixel(0, 0, 0);
      send_pixel(4095, 0, 1);
      send_pixel(0, 4095, 0);
      send_pixel(4095, 4095, 2);
      send_pixel(800, 450, 0);
      send_pixel(1067, 0, 0);
      send_pixel(400, 450, 1);
      send_pixel(1215, 450, 0);
      send_pixel(1600, 450, 0);
      send_pixel(12'hAAA, 12'h555, 0);
      send_pixel(12'h555, 12'hAAA, 3);
      send_pixel(700, 200, 0);
      req_chan.valid <= 1'b0;

      load_view(mep_pkg::X_START_RESET, mep_pkg::Y_START_RESET, mep_pkg::X_STEP_RESET,
                mep_pkg::Y_STEP_RESET, 32'd1);
      send_pixel(800, 450, 0);
      send_pixel(1700, 450, 0);
      send_pixel(0, 0, 0);
      req_chan.valid <= 1'b0;

      load_view(mep_pkg::X_START_RESET, mep_pkg::Y_START_RESET, mep_pkg::X_STEP_RESET,
                mep_pkg::Y_STEP_RESET, 32'd0);
      send_pixel(0, 0, 0);
      send_pixel(800, 450, 1);
      req_chan.valid <= 1'b0;

      // coordinates saturate
      load_view(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd5);
      send_pixel(4095, 4095, 0);
      send_pixel(0, 0, 0);
      send_pixel(1, 1, 0);
      req_chan.valid <= 1'b0;

      load_view(32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0, 32'd1023);
      send_pixel(4095, 4095, 0);
      send_pixel(0, 0, 0);
      req_chan.valid <= 1'b0;

      load_view(mep_pkg::X_START_RESET, mep_pkg::Y_START_RESET, mep_pkg::X_STEP_RESET,
                mep_pkg::Y_STEP_RESET, mep_pkg::LIMIT_RESET);
      hold_pending = 1'b1;
      scatter_pixels(150, 1600, 900);

      repeat (5) begin
         random_view(2, 64);
         scatter_pixels(60, 4095, 4095);
      end

      // zoom on the boundary at the deepest limit
      load_view(-32'd214748365, 32'd40265318, 32'd6554, 32'd6554, 32'd1023);
      scatter_pixels(12, 4095, 4095);

      load_view(-$urandom_range(0, 536870912), $urandom_range(0, 268435456), 32'd0, 32'd0,
                $urandom_range(2, 200));
      scatter_pixels(20, 4095, 4095);

      load_view($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 255));
      scatter_pixels(40, 4095, 4095);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d pixel results over %0d register settings, limits 0 to 1023.",
               ledger.checked, view_count);
      $display("%0d results had the inside color, %0d escaped; %0d mismatches.",
               ledger.inside_count, ledger.checked - ledger.inside_count, ledger.faults);
      if (ledger.faults == 0 && ledger.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
